[hdl/hnt_pkg.sv]
// Shared types, constants and letter tables for the Hangul byte converter.
// No dependencies.
package hnt_pkg;

   localparam logic [7:0] EmptySlot = 8'h80;
   localparam logic [7:0] ShiftOut  = 8'h0E;
   localparam logic [7:0] ShiftIn   = 8'h0F;
   localparam logic [7:0] CodeBase  = 8'd128;

   localparam int MaxBytes = 5;
   localparam int CntW     = 3;
   localparam int QDepth   = 4;
   localparam int QAw      = 2;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CntW-1:0]          cnt;
   } plan_type;

   typedef struct packed {
      logic     valid;
      plan_type plan;
   } qwr_type;

   function automatic logic [7:0] to_code(input logic [4:0] idx);
      return CodeBase + {3'b000, idx};
   endfunction

   function automatic logic [4:0] initial_idx(input logic [7:0] c);
      logic [4:0] r;
      unique case (c)
         8'h41: r = 5'd1;   // A
         8'h42: r = 5'd2;   // B
         8'h44: r = 5'd3;   // D
         8'h47: r = 5'd4;   // G
         8'h48: r = 5'd5;   // H
         8'h49: r = 5'd6;   // I
         8'h51: r = 5'd7;   // Q
         8'h52: r = 5'd8;   // R
         8'h53: r = 5'd9;   // S
         8'h55: r = 5'd10;  // U
         8'h56: r = 5'd11;  // V
         8'h57: r = 5'd12;  // W
         8'h58: r = 5'd13;  // X
         8'h59: r = 5'd14;  // Y
         8'h5A: r = 5'd15;  // Z
         8'h5B: r = 5'd16;  // [
         8'h5C: r = 5'd17;  // backslash
         8'h5D: r = 5'd18;  // ]
         8'h5E: r = 5'd19;  // ^
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] vowel_idx(input logic [7:0] c);
      logic [4:0] r;
      unique case (c)
         8'h62: r = 5'd1;   // b
         8'h63: r = 5'd2;   // c
         8'h64: r = 5'd3;   // d
         8'h65: r = 5'd4;   // e
         8'h66: r = 5'd5;   // f
         8'h67: r = 5'd6;   // g
         8'h6A: r = 5'd7;   // j
         8'h6B: r = 5'd8;   // k
         8'h6C: r = 5'd9;   // l
         8'h6D: r = 5'd10;  // m
         8'h6E: r = 5'd11;  // n
         8'h6F: r = 5'd12;  // o
         8'h72: r = 5'd13;  // r
         8'h73: r = 5'd14;  // s
         8'h74: r = 5'd15;  // t
         8'h75: r = 5'd16;  // u
         8'h76: r = 5'd17;  // v
         8'h77: r = 5'd18;  // w
         8'h7A: r = 5'd19;  // z
         8'h7B: r = 5'd20;  // {
         8'h7C: r = 5'd21;  // |
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] final_idx(input logic [7:0] c);
      logic [4:0] r;
      unique case (c)
         8'h41: r = 5'd1;   // A
         8'h42: r = 5'd2;   // B
         8'h43: r = 5'd3;   // C
         8'h44: r = 5'd4;   // D
         8'h45: r = 5'd5;   // E
         8'h46: r = 5'd6;   // F
         8'h47: r = 5'd7;   // G
         8'h49: r = 5'd8;   // I
         8'h4A: r = 5'd9;   // J
         8'h4B: r = 5'd10;  // K
         8'h4C: r = 5'd11;  // L
         8'h4D: r = 5'd12;  // M
         8'h4E: r = 5'd13;  // N
         8'h4F: r = 5'd14;  // O
         8'h50: r = 5'd15;  // P
         8'h51: r = 5'd16;  // Q
         8'h52: r = 5'd17;  // R
         8'h53: r = 5'd18;  // S
         8'h55: r = 5'd19;  // U
         8'h56: r = 5'd20;  // V
         8'h57: r = 5'd21;  // W
         8'h58: r = 5'd22;  // X
         8'h5A: r = 5'd23;  // Z
         8'h5B: r = 5'd24;  // [
         8'h5C: r = 5'd25;  // backslash
         8'h5D: r = 5'd26;  // ]
         8'h5E: r = 5'd27;  // ^
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] cvowel_idx(input logic [7:0] c, input logic [7:0] n);
      logic [4:0] r;
      r = 5'd0;
      if (c == 8'h6C) begin
         if (n == 8'h62) r = 5'd10;
         else if (n == 8'h63) r = 5'd11;
         else if (n == 8'h7C) r = 5'd12;
      end else if (c == 8'h73) begin
         if (n == 8'h66) r = 5'd15;
         else if (n == 8'h67) r = 5'd16;
         else if (n == 8'h7C) r = 5'd17;
      end else if (c == 8'h7A) begin
         if (n == 8'h7C) r = 5'd20;
      end
      return r;
   endfunction

   function automatic logic [4:0] cfinal_idx(input logic [7:0] c, input logic [7:0] n);
      logic [4:0] r;
      r = 5'd0;
      if (c == 8'h41) begin
         if (n == 8'h55) r = 5'd3;
      end else if (c == 8'h44) begin
         if (n == 8'h58) r = 5'd5;
         else if (n == 8'h5E) r = 5'd6;
      end else if (c == 8'h49) begin
         if (n == 8'h41) r = 5'd9;
         else if (n == 8'h51) r = 5'd10;
         else if (n == 8'h52) r = 5'd11;
         else if (n == 8'h55) r = 5'd12;
         else if (n == 8'h5C) r = 5'd13;
         else if (n == 8'h5D) r = 5'd14;
         else if (n == 8'h5E) r = 5'd15;
      end else if (c == 8'h52) begin
         if (n == 8'h55) r = 5'd18;
      end
      return r;
   endfunction

endpackage

[hdl/hangul_nbyte_to_three_byte_top.sv]
// Top level of the Hangul shifted-byte to three-byte syllable converter.
// Depends on hnt_pkg, hnt_front, hnt_queue and hnt_back.
//
// The block takes one source byte (with its two lookahead bytes) per clock while
// full is low and emits between zero and five result bytes for it, one per clock
// while pop is taken; last_of_run marks the final byte of each item. Items that
// give no result (shift codes, absorbed lookahead) are taken at the input and
// never reach the queue. A four-entry plan queue separates the automaton from the
// byte sequencer, so sustained throughput is one result byte per cycle while pop
// is taken and the queue holds plans.
module hangul_nbyte_to_three_byte_top
   import hnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_cur_byte,
   input  logic [7:0] req_next_byte,
   input  logic [7:0] req_after_next_byte,
   input  logic       req_is_terminator,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   qwr_type  q_wr;
   logic     q_full, q_pop, q_valid;
   plan_type q_head;

   assign full = q_full;

   hnt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .cur_byte        (req_cur_byte),
      .next_byte       (req_next_byte),
      .after_next_byte (req_after_next_byte),
      .is_terminator   (req_is_terminator),
      .q_full          (q_full),
      .q_wr            (q_wr)
   );

   hnt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   hnt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .out_byte    (rsp_out_byte),
      .last_of_run (rsp_last_of_run)
   );

endmodule

[hdl/hnt_front.sv]
// Front end: accepts source bytes, runs the jamo automaton and builds output plans.
// Depends on hnt_pkg.
module hnt_front
   import hnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] cur_byte,
   input  logic [7:0] next_byte,
   input  logic [7:0] after_next_byte,
   input  logic       is_terminator,
   input  logic       q_full,
   output qwr_type    q_wr
);

   typedef enum logic [1:0] {
      ModeAscii   = 2'd0,
      ModeInitial = 2'd1,
      ModeMedial  = 2'd2,
      ModeFinal   = 2'd3
   } mode_type;

   mode_type mode_ff, mode_in;
   logic     skip_ff, skip_in;
   plan_type plan;
   logic     accept;
   logic [4:0] ini, vow, fin, cvw, cfn;
   logic       nvow, nnvow;

   assign accept = push && !q_full;
   assign ini    = initial_idx(cur_byte);
   assign vow    = vowel_idx(cur_byte);
   assign fin    = final_idx(cur_byte);
   assign cvw    = cvowel_idx(cur_byte, next_byte);
   assign cfn    = cfinal_idx(cur_byte, next_byte);
   assign nvow   = vowel_idx(next_byte) != 5'd0;
   assign nnvow  = vowel_idx(after_next_byte) != 5'd0;

   always_comb begin
      plan.bytes = {MaxBytes{EmptySlot}};
      plan.cnt   = '0;
      mode_in    = mode_ff;
      skip_in    = skip_ff;
      if (is_terminator) begin
         skip_in        = 1'b0;
         plan.bytes[0]  = 8'h00;
         plan.cnt       = 3'd1;
      end else if (skip_ff) begin
         skip_in = 1'b0;
      end else begin
         unique case (mode_ff)
            ModeAscii: begin
               if (cur_byte == ShiftOut) begin
                  mode_in = ModeInitial;
               end else begin
                  plan.bytes[0] = cur_byte;
                  plan.cnt      = 3'd1;
               end
            end
            ModeInitial: begin
               if (ini != 5'd0) begin
                  plan.bytes[0] = to_code(ini);
                  plan.cnt      = 3'd1;
                  mode_in       = ModeMedial;
               end else if (vow != 5'd0) begin
                  plan.bytes[1] = to_code(vow);
                  plan.cnt      = 3'd3;
               end else if (fin != 5'd0) begin
                  plan.bytes[2] = to_code(fin);
                  plan.cnt      = 3'd3;
               end else if (cur_byte == ShiftIn) begin
                  mode_in = ModeAscii;
               end else begin
                  plan.bytes[0] = cur_byte;
                  plan.cnt      = 3'd1;
               end
            end
            ModeMedial: begin
               if (cvw != 5'd0) begin
                  plan.bytes[0] = to_code(cvw);
                  plan.cnt      = 3'd1;
                  mode_in       = ModeFinal;
                  skip_in       = 1'b1;
               end else if (vow != 5'd0) begin
                  plan.bytes[0] = to_code(vow);
                  plan.cnt      = 3'd1;
                  mode_in       = ModeFinal;
               end else if (ini != 5'd0) begin
                  plan.bytes[2] = to_code(ini);
                  plan.cnt      = 3'd3;
               end else if (fin != 5'd0) begin
                  plan.bytes[4] = to_code(fin);
                  plan.cnt      = 3'd5;
                  mode_in       = ModeInitial;
               end else if (cur_byte == ShiftIn) begin
                  plan.cnt = 3'd2;
                  mode_in  = ModeAscii;
               end else begin
                  plan.bytes[2] = cur_byte;
                  plan.cnt      = 3'd3;
               end
            end
            ModeFinal: begin
               if (ini != 5'd0 && nvow) begin
                  plan.bytes[1] = to_code(ini);
                  plan.cnt      = 3'd2;
                  mode_in       = ModeMedial;
               end else if (cfn != 5'd0 && !nnvow) begin
                  plan.bytes[0] = to_code(cfn);
                  plan.cnt      = 3'd1;
                  mode_in       = ModeInitial;
                  skip_in       = 1'b1;
               end else if (fin != 5'd0) begin
                  plan.bytes[0] = to_code(fin);
                  plan.cnt      = 3'd1;
                  mode_in       = ModeInitial;
               end else if (ini != 5'd0) begin
                  plan.bytes[1] = to_code(ini);
                  plan.cnt      = 3'd2;
                  mode_in       = ModeMedial;
               end else if (vow != 5'd0) begin
                  plan.bytes[2] = to_code(vow);
                  plan.cnt      = 3'd4;
                  mode_in       = ModeInitial;
               end else if (cur_byte == ShiftIn) begin
                  plan.cnt = 3'd1;
                  mode_in  = ModeAscii;
               end else begin
                  plan.bytes[1] = cur_byte;
                  plan.cnt      = 3'd2;
                  mode_in       = ModeInitial;
               end
            end
            default: begin
               mode_in = ModeAscii;
            end
         endcase
      end
   end

   assign q_wr.valid = accept && (plan.cnt != '0);
   assign q_wr.plan  = plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeAscii;
         skip_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         skip_ff <= skip_in;
      end
   end

endmodule

[hdl/hnt_queue.sv]
// Short plan queue between the front end and the byte sequencer.
// Depends on hnt_pkg.
module hnt_queue
   import hnt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  qwr_type  q_wr,
   output logic     q_full,
   input  logic     q_pop,
   output logic     q_valid,
   output plan_type q_head
);

   plan_type          mem_ff [QDepth];
   logic [QAw-1:0]    head_ff, head_in;
   logic [QAw-1:0]    tail_ff, tail_in;
   logic [QAw:0]      count_ff, count_in;

   assign q_full  = count_ff == (QAw+1)'(QDepth);
   assign q_valid = count_ff != '0;
   assign q_head  = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (q_wr.valid) begin
         tail_in = tail_ff + 1'b1;
      end
      if (q_pop) begin
         head_in = head_ff + 1'b1;
      end
      if (q_wr.valid && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_wr.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.valid) begin
         mem_ff[tail_ff] <= q_wr.plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAw+1)'(QDepth))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.valid |-> !q_full)
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule

[hdl/hnt_back.sv]
// Byte sequencer: takes plans from the queue and delivers their bytes one per word.
// Depends on hnt_pkg.
module hnt_back
   import hnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  plan_type   q_head,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] out_byte,
   output logic       last_of_run
);

   plan_type        cur_ff, cur_in;
   logic            busy_ff, busy_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic            take, last, done;

   assign last  = idx_ff == (cur_ff.cnt - 1'b1);
   assign take  = pop && busy_ff;
   assign done  = !busy_ff || (take && last);
   assign q_pop = done && q_valid;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         cur_in  = q_head;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take && last) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign empty       = !busy_ff;
   assign out_byte    = cur_ff.bytes[idx_ff];
   assign last_of_run = last;

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.cnt != '0 && idx_ff < cur_ff.cnt))
      else $error("sequencer index outside plan");

   a_hold_mid_run: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !pop) |=> (busy_ff && $stable(idx_ff)))
      else $error("word changed while stalled");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("index did not advance");

endmodule
